// ===== design/rau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg: shared definitions for the rational arithmetic unit
// Operation and status codes, default sizes and the control word that
// travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int OPERAND_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH_DEF   = 2;

	// operation codes
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_ZERO_DEN  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;

	// classification of one item
	typedef struct packed {
		logic sum_mode;  // numerator is a signed sum of two products
		logic den_zero;  // an operand denominator is zero
		logic neg1;      // sign of the first numerator product
		logic neg2;      // sign of the second product, subtract folded in
		logic dneg;      // sign of the denominator product
	} rau_ctl_t;

endpackage

// ===== design/rau_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_front: operand classification
// Splits the operands into sign and magnitude, picks the product pairs for
// the operation and flags zero denominators.
// ----------------------------------------------------------------------------
module rau_front
	import rau_pkg::*;
#(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF,
	localparam int MW = OPERAND_WIDTH + 1
) (
	input  logic [1:0]               req_type,
	input  logic [OPERAND_WIDTH-1:0] a_num,
	input  logic [OPERAND_WIDTH-1:0] a_den,
	input  logic [OPERAND_WIDTH-1:0] b_num,
	input  logic [OPERAND_WIDTH-1:0] b_den,
	output rau_ctl_t                 ctl,
	output logic [MW-1:0]            p1a,
	output logic [MW-1:0]            p1b,
	output logic [MW-1:0]            p2a,
	output logic [MW-1:0]            p2b,
	output logic [MW-1:0]            pda,
	output logic [MW-1:0]            pdb
);

	logic an_neg, ad_neg, bn_neg, bd_neg;
	logic [MW-1:0] an_mag, ad_mag, bn_mag, bd_mag;

	assign an_neg = a_num[OPERAND_WIDTH-1];
	assign ad_neg = a_den[OPERAND_WIDTH-1];
	assign bn_neg = b_num[OPERAND_WIDTH-1];
	assign bd_neg = b_den[OPERAND_WIDTH-1];

	// magnitude needs one bit more than the operand for the most negative value
	assign an_mag = an_neg ? MW'(-{an_neg, a_num}) : {1'b0, a_num};
	assign ad_mag = ad_neg ? MW'(-{ad_neg, a_den}) : {1'b0, a_den};
	assign bn_mag = bn_neg ? MW'(-{bn_neg, b_num}) : {1'b0, b_num};
	assign bd_mag = bd_neg ? MW'(-{bd_neg, b_den}) : {1'b0, b_den};

	always_comb begin
		ctl.den_zero = (a_den == '0) || (b_den == '0);
		ctl.sum_mode = 1'b0;
		ctl.neg1     = an_neg ^ bd_neg;
		ctl.neg2     = 1'b0;
		ctl.dneg     = ad_neg ^ bd_neg;
		p1a = an_mag;
		p1b = bd_mag;
		p2a = '0;
		p2b = '0;
		pda = ad_mag;
		pdb = bd_mag;
		case (req_type)
			OP_ADD, OP_SUB: begin
				ctl.sum_mode = 1'b1;
				ctl.neg2     = bn_neg ^ ad_neg ^ (req_type == OP_SUB);
				p2a = bn_mag;
				p2b = ad_mag;
			end
			OP_MUL: begin
				ctl.neg1 = an_neg ^ bn_neg;
				p1b = bn_mag;
			end
			OP_DIV: begin
				ctl.dneg = ad_neg ^ bn_neg;
				pdb = bn_mag;
			end
			default: begin
				ctl.sum_mode = 1'b0;
			end
		endcase
	end

endmodule

// ===== design/rau_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_queue: short FIFO between front and back end
// Register-based; push is dropped when full, pop when empty.
// ----------------------------------------------------------------------------
module rau_queue
	import rau_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             nonempty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full     = (cnt_q == CW'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== design/rau_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_back: product, reduction and result sequencer
// One shared multiplier for the three products, signed sum, binary gcd, then a
// radix-2 divide of numerator and denominator by the gcd side by side.
// ----------------------------------------------------------------------------
module rau_back
	import rau_pkg::*;
#(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF,
	localparam int MW = OPERAND_WIDTH + 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           ent_valid,
	output logic           ent_pop,
	input  rau_ctl_t       ent_ctl,
	input  logic [MW-1:0]  ent_p1a,
	input  logic [MW-1:0]  ent_p1b,
	input  logic [MW-1:0]  ent_p2a,
	input  logic [MW-1:0]  ent_p2b,
	input  logic [MW-1:0]  ent_pda,
	input  logic [MW-1:0]  ent_pdb,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [31:0]    res_num,
	output logic [30:0]    res_den,
	output logic [1:0]     status
);

	localparam int PW  = 2 * MW;
	localparam int NW  = PW + 1;
	localparam int CW  = (NW > 33) ? NW : 33;
	localparam int CNW = $clog2(NW);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MUL1  = 4'd1;
	localparam logic [3:0] S_MUL2  = 4'd2;
	localparam logic [3:0] S_MUL3  = 4'd3;
	localparam logic [3:0] S_SUM   = 4'd4;
	localparam logic [3:0] S_CHECK = 4'd5;
	localparam logic [3:0] S_TWOS  = 4'd6;
	localparam logic [3:0] S_GCD   = 4'd7;
	localparam logic [3:0] S_DIV   = 4'd8;
	localparam logic [3:0] S_FIN   = 4'd9;

	logic [3:0]     state_q, state_d;
	rau_ctl_t       ctl_q;
	logic [MW-1:0]  p1a_q, p1b_q, p2a_q, p2b_q, pda_q, pdb_q;
	logic [MW-1:0]  mul_a, mul_b;
	logic [PW-1:0]  prod;
	logic [PW-1:0]  m1_q, m2_q, dm_q;
	logic [NW-1:0]  e1, e2, nsum;
	logic           nsum_neg;
	logic [NW-1:0]  nmag_q;
	logic           nneg_q;
	logic [NW-1:0]  x_q, y_q, n0_q, d0_q;
	logic [NW:0]    rn_q, rd_q, rn_nx, rd_nx, g_ext;
	logic           qn_bit, qd_bit;
	logic [CNW-1:0] cnt_q;
	logic           neg_q, early_q, early;
	logic [1:0]     st_q;
	logic           out_valid_q, out_free;
	logic [31:0]    res_num_q, fin_num;
	logic [30:0]    res_den_q, fin_den;
	logic [1:0]     status_q, fin_st;
	logic [CW-1:0]  nq, dq;
	logic           ovf;
	logic [NW-1:0]  x_sub_y, y_sub_x;

	assign ent_pop  = (state_q == S_IDLE) && ent_valid;
	assign out_free = !out_valid_q || out_ready;
	assign early    = ctl_q.den_zero || (dm_q == '0) || (nmag_q == '0);

	// shared multiplier
	always_comb begin
		case (state_q)
			S_MUL1: begin
				mul_a = p1a_q;
				mul_b = p1b_q;
			end
			S_MUL2: begin
				mul_a = p2a_q;
				mul_b = p2b_q;
			end
			default: begin
				mul_a = pda_q;
				mul_b = pdb_q;
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	// signed-magnitude sum of the two numerator products, or the first product alone outside sum mode
	assign e1 = {1'b0, m1_q};
	assign e2 = {1'b0, m2_q};
	always_comb begin
		if (!ctl_q.sum_mode) begin
			nsum     = e1;
			nsum_neg = ctl_q.neg1;
		end else if (ctl_q.neg1 == ctl_q.neg2) begin
			nsum     = e1 + e2;
			nsum_neg = ctl_q.neg1;
		end else if (m1_q >= m2_q) begin
			nsum     = e1 - e2;
			nsum_neg = ctl_q.neg1;
		end else begin
			nsum     = e2 - e1;
			nsum_neg = ctl_q.neg2;
		end
	end

	assign x_sub_y = x_q - y_q;
	assign y_sub_x = y_q - x_q;

	// restoring divide step, x_q holds the odd gcd
	assign g_ext  = {1'b0, x_q};
	assign rn_nx  = {rn_q[NW-1:0], n0_q[NW-1]};
	assign rd_nx  = {rd_q[NW-1:0], d0_q[NW-1]};
	assign qn_bit = (rn_nx >= g_ext);
	assign qd_bit = (rd_nx >= g_ext);

	// result formatting
	assign nq = CW'(n0_q);
	assign dq = CW'(d0_q);
	always_comb begin
		ovf = (dq > CW'(32'h7FFF_FFFF)) ||
			(neg_q ? (nq > CW'(32'h8000_0000)) : (nq > CW'(32'h7FFF_FFFF)));
		if (early_q || ovf) begin
			fin_num = '0;
			fin_den = 31'd1;
			fin_st  = early_q ? st_q : ST_OVERFLOW;
		end else begin
			fin_num = neg_q ? (32'd0 - nq[31:0]) : nq[31:0];
			fin_den = dq[30:0];
			fin_st  = ST_OK;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (ent_valid) state_d = S_MUL1;
			S_MUL1:  state_d = S_MUL2;
			S_MUL2:  state_d = S_MUL3;
			S_MUL3:  state_d = S_SUM;
			S_SUM:   state_d = S_CHECK;
			S_CHECK: state_d = early ? S_FIN : S_TWOS;
			S_TWOS:  if (x_q[0] || y_q[0]) state_d = S_GCD;
			S_GCD:   if (x_q == y_q) state_d = S_DIV;
			S_DIV:   if (cnt_q == '0) state_d = S_FIN;
			S_FIN:   if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (ent_valid) begin
					ctl_q <= ent_ctl;
					p1a_q <= ent_p1a;
					p1b_q <= ent_p1b;
					p2a_q <= ent_p2a;
					p2b_q <= ent_p2b;
					pda_q <= ent_pda;
					pdb_q <= ent_pdb;
				end
			end
			S_MUL1: m1_q <= prod;
			S_MUL2: m2_q <= prod;
			S_MUL3: dm_q <= prod;
			S_SUM: begin
				nmag_q <= nsum;
				nneg_q <= nsum_neg;
			end
			S_CHECK: begin
				early_q <= early;
				st_q    <= (ctl_q.den_zero || dm_q == '0) ? ST_ZERO_DEN : ST_OK;
				neg_q   <= nneg_q ^ ctl_q.dneg;
				x_q     <= nmag_q;
				y_q     <= {1'b0, dm_q};
				n0_q    <= nmag_q;
				d0_q    <= {1'b0, dm_q};
			end
			S_TWOS: begin
				// common factors of two come off the dividends as well
				if (!x_q[0] && !y_q[0]) begin
					x_q  <= x_q >> 1;
					y_q  <= y_q >> 1;
					n0_q <= n0_q >> 1;
					d0_q <= d0_q >> 1;
				end
			end
			S_GCD: begin
				if (x_q == y_q) begin
					rn_q  <= '0;
					rd_q  <= '0;
					cnt_q <= CNW'(NW - 1);
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (x_q > y_q) begin
					x_q <= x_sub_y >> 1;
				end else begin
					y_q <= y_sub_x >> 1;
				end
			end
			S_DIV: begin
				rn_q  <= qn_bit ? (rn_nx - g_ext) : rn_nx;
				rd_q  <= qd_bit ? (rd_nx - g_ext) : rd_nx;
				n0_q  <= {n0_q[NW-2:0], qn_bit};
				d0_q  <= {d0_q[NW-2:0], qd_bit};
				cnt_q <= cnt_q - 1'b1;
			end
			S_FIN: begin
				if (out_free) begin
					res_num_q <= fin_num;
					res_den_q <= fin_den;
					status_q  <= fin_st;
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign res_num   = res_num_q;
	assign res_den   = res_den_q;
	assign status    = status_q;

endmodule

// ===== design/rational_arith_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_unit: exact fraction arithmetic with gcd reduction
// Adds, subtracts, multiplies or divides two signed fractions and returns the
// reduced result with a positive denominator and a status code.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is classified at once and written into
// a short queue (QUEUE_DEPTH items), so the input keeps taking items while the
// back end is busy or a result waits at the output, as long as the queue has
// room. The back end works on one item at a time: it takes the item from the
// queue, forms the three products on the single shared multiplier, then the
// signed sum, then the checks, then strips common factors of two (shifting
// until one side is odd), runs binary-gcd steps until both sides are equal
// and ends with radix-2 division over NW quotient bits, where NW =
// 2*OPERAND_WIDTH+3 (35 at the default width), before loading the output
// register. Items end early on a zero operand or result denominator
// (status 1) or a zero numerator (0/1), and skip the gcd and the divider.
// A result held at the output keeps the back end in its final state until
// it goes.
// A numerator outside the signed 32-bit range or a denominator above
// 2^31-1 reports status 2.
// Any non-zero status comes with res_num 0 and res_den 1.
// ----------------------------------------------------------------------------
module rational_arith_unit
	import rau_pkg::*;
#(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF,
	parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               req_type,
	input  logic [OPERAND_WIDTH-1:0] a_num,
	input  logic [OPERAND_WIDTH-1:0] a_den,
	input  logic [OPERAND_WIDTH-1:0] b_num,
	input  logic [OPERAND_WIDTH-1:0] b_den,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [31:0]              res_num,
	output logic [30:0]              res_den,
	output logic [1:0]               status
);

	localparam int MW = OPERAND_WIDTH + 1;
	localparam int QW = $bits(rau_ctl_t) + 6 * MW;

	// front end outputs
	rau_ctl_t      f_ctl;
	logic [MW-1:0] f_p1a, f_p1b, f_p2a, f_p2b, f_pda, f_pdb;

	// queue
	logic          q_full, q_nonempty, q_pop;
	logic [QW-1:0] q_wdata, q_rdata;

	// entry as seen by the back end
	rau_ctl_t      e_ctl;
	logic [MW-1:0] e_p1a, e_p1b, e_p2a, e_p2b, e_pda, e_pdb;

	rau_front #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_front (
		.req_type(req_type),
		.a_num   (a_num),
		.a_den   (a_den),
		.b_num   (b_num),
		.b_den   (b_den),
		.ctl     (f_ctl),
		.p1a     (f_p1a),
		.p1b     (f_p1b),
		.p2a     (f_p2a),
		.p2b     (f_p2b),
		.pda     (f_pda),
		.pdb     (f_pdb)
	);

	// a transfer lands in the queue whenever there is room
	assign in_ready = !q_full;
	assign q_wdata  = {f_ctl, f_p1a, f_p1b, f_p2a, f_p2b, f_pda, f_pdb};

	rau_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid),
		.push_data(q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_rdata),
		.nonempty (q_nonempty)
	);

	assign {e_ctl, e_p1a, e_p1b, e_p2a, e_p2b, e_pda, e_pdb} = q_rdata;

	rau_back #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.ent_valid(q_nonempty),
		.ent_pop  (q_pop),
		.ent_ctl  (e_ctl),
		.ent_p1a  (e_p1a),
		.ent_p1b  (e_p1b),
		.ent_p2a  (e_p2a),
		.ent_p2b  (e_p2b),
		.ent_pda  (e_pda),
		.ent_pdb  (e_pdb),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res_num  (res_num),
		.res_den  (res_den),
		.status   (status)
	);

	// back end only pops an item that is there
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_nonempty)
		else $error("back end popped an empty queue");

	// denominator is never zero on a result
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (res_den != '0))
		else $error("result denominator is zero");

	// error results and zero results are 0/1
	a_err_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_OK || res_num == '0)) |->
		(res_num == '0 && res_den == 31'd1))
		else $error("error or zero result not reported as 0/1");

endmodule
